// ===== design/direct_mapped_writeback_cache_unit_defines.svh =====
// Assertion macros shared by the cache unit RTL.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define DMWBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define DMWBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dmwbc_pkg.sv =====
// Shared types and constants of the direct-mapped write-back cache unit.
package dmwbc_pkg;

	// Fixed field widths.
	localparam int ADDR_W = 16;
	localparam int DATA_W = 32;
	localparam int TIME_W = 32;
	localparam int COST_W = 10;
	localparam int FUNC_W = 2;
	localparam int REG_W  = 2;

	// Access codes of the func field.
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_W-1:0] REG_MEM_READ_COST   = 2'd0;
	localparam logic [REG_W-1:0] REG_MEM_WRITE_COST  = 2'd1;
	localparam logic [REG_W-1:0] REG_CACHE_READ_COST = 2'd2;
	localparam logic [REG_W-1:0] REG_CACHE_WRITE_COST = 2'd3;

	// Cost register reset values.
	localparam logic [COST_W-1:0] MEM_READ_COST_RST    = 10'd100;
	localparam logic [COST_W-1:0] MEM_WRITE_COST_RST   = 10'd50;
	localparam logic [COST_W-1:0] CACHE_READ_COST_RST  = 10'd1;
	localparam logic [COST_W-1:0] CACHE_WRITE_COST_RST = 10'd1;

	// Sequencer states.
	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_TAG   = 7'b0000100,
		ST_WB    = 7'b0001000,
		ST_FILL  = 7'b0010000,
		ST_WORD  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

endpackage

// ===== design/direct_mapped_writeback_cache_unit.sv =====
// Direct-mapped write-back cache unit with its backing memory and time counter.
//
// Input channel (in_valid/in_stall) carries one access word: func, address and
// write_data. func selects read, write or clear of the time counter. Output
// channel (out_valid/out_stall) returns one result word per access: read_data,
// hit, wrote_back and elapsed_time. The cfg port writes the four cost registers,
// to be written only while the unit is idle; the unit does not enforce this.
// A miss fills the line from the backing memory one word a cycle, after moving a
// dirty victim line out to it the same way. The result shows up in the same cycle
// that the unit can take its next word.
// After reset the unit zeroes the backing memory and the tag store, one word a
// cycle, over all MEMORY_BYTES/4 backing words; in_stall stays high then.
// A new word is taken while an earlier result still waits in the output
// register; a stalled output holds, and the unit waits only when a second
// result is ready before the first has been taken.
`include "direct_mapped_writeback_cache_unit_defines.svh"

module direct_mapped_writeback_cache_unit
	import dmwbc_pkg::*;
#(
	parameter int LINE_COUNT   = 256,
	parameter int LINE_BYTES   = 64,
	parameter int MEMORY_BYTES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] read_data,
	output logic              hit,
	output logic              wrote_back,
	output logic [TIME_W-1:0] elapsed_time,
	input  logic              cfg_write,
	input  logic [REG_W-1:0]  cfg_index,
	input  logic [COST_W-1:0] cfg_data
);

	// Geometry derived from the parameters.
	localparam int WPL      = LINE_BYTES / 4;
	localparam int OFF_W    = $clog2(LINE_BYTES);
	localparam int WO_W     = $clog2(WPL);
	localparam int IDX_W    = $clog2(LINE_COUNT);
	localparam int TAG_LSB  = OFF_W + IDX_W;
	localparam int TAG_RAW  = ADDR_W - TAG_LSB;
	localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int META_W   = TAG_W + 2;
	localparam int LW       = IDX_W + WO_W;
	localparam int BW       = $clog2(MEMORY_BYTES) - 2;
	localparam int BWC      = MEMORY_BYTES / 4;
	localparam int CNT_W    = WO_W + 1;
	localparam logic [CNT_W-1:0] WPL_CNT = CNT_W'(WPL);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// Memories: tag store, line data and backing words.
	logic [META_W-1:0] meta_mem [LINE_COUNT];
	logic [DATA_W-1:0] line_mem [LINE_COUNT*WPL];
	logic [DATA_W-1:0] back_mem [BWC];

	// Control and pipeline registers.
	state_t            state_q;
	logic [BW-1:0]     clr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FUNC_W-1:0] func_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TAG_W-1:0]  tag_q;
	logic [WO_W-1:0]   word_q;
	logic [DATA_W-1:0] wdata_q;
	logic [BW-1:0]     nbase_q;
	logic [BW-1:0]     vbase_q;
	logic              hit_q;
	logic              wb_q;
	logic              dirty_q;
	logic [TIME_W-1:0] time_q;
	logic [COST_W-1:0] mem_read_cost_q;
	logic [COST_W-1:0] mem_write_cost_q;
	logic [COST_W-1:0] cache_read_cost_q;
	logic [COST_W-1:0] cache_write_cost_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_hit_q;
	logic              out_wb_q;
	logic [TIME_W-1:0] out_time_q;

	// Memory read data.
	logic [META_W-1:0] meta_rd_q;
	logic [DATA_W-1:0] line_rd_q;
	logic [DATA_W-1:0] back_rd_q;

	// Memory port controls.
	logic              meta_re;
	logic [IDX_W-1:0]  meta_raddr;
	logic              meta_we;
	logic [IDX_W-1:0]  meta_waddr;
	logic [META_W-1:0] meta_wdata;
	logic              line_re;
	logic [LW-1:0]     line_raddr;
	logic              line_we;
	logic [LW-1:0]     line_waddr;
	logic [DATA_W-1:0] line_wdata;
	logic              back_re;
	logic [BW-1:0]     back_raddr;
	logic              back_we;
	logic [BW-1:0]     back_waddr;
	logic [DATA_W-1:0] back_wdata;

	// Address decode of the incoming word and of the stored victim.
	logic              in_accept;
	logic              out_load;
	logic [IDX_W-1:0]  in_idx;
	logic [TAG_W-1:0]  in_tag;
	logic [WO_W-1:0]   in_word;
	logic [31:0]       in_blk;
	logic              meta_valid;
	logic              meta_dirty;
	logic [TAG_W-1:0]  meta_tag;
	logic              tag_hit;
	logic [31:0]       victim_blk;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign in_idx  = IDX_W'(address >> OFF_W);
	assign in_tag  = TAG_W'(address >> TAG_LSB);
	assign in_word = WO_W'(address >> 2);
	assign in_blk  = 32'(address >> OFF_W) << (OFF_W - 2);

	assign meta_valid = meta_rd_q[TAG_W+1];
	assign meta_dirty = meta_rd_q[TAG_W];
	assign meta_tag   = meta_rd_q[TAG_W-1:0];
	assign tag_hit    = meta_valid && (meta_tag == tag_q);
	assign victim_blk = ((32'(meta_tag) << IDX_W) | 32'(idx_q)) << (OFF_W - 2);

	// Memory port steering for each state.
	always_comb begin
		meta_re    = 1'b0;
		meta_raddr = in_idx;
		meta_we    = 1'b0;
		meta_waddr = idx_q;
		meta_wdata = {1'b1, (func_q == FUNC_WRITE) || dirty_q, tag_q};
		line_re    = 1'b0;
		line_raddr = {idx_q, word_q};
		line_we    = 1'b0;
		line_waddr = {idx_q, word_q};
		line_wdata = wdata_q;
		back_re    = 1'b0;
		back_raddr = nbase_q + BW'(cnt_q);
		back_we    = 1'b0;
		back_waddr = vbase_q + BW'(cnt_q - CNT_ONE);
		back_wdata = line_rd_q;
		unique case (state_q)
			ST_CLEAR: begin
				back_we    = 1'b1;
				back_waddr = clr_q;
				back_wdata = '0;
				meta_we    = (clr_q < BW'(LINE_COUNT));
				meta_waddr = IDX_W'(clr_q);
				meta_wdata = '0;
			end
			ST_IDLE: begin
				meta_re = 1'b1;
			end
			ST_WB: begin
				line_re    = (cnt_q < WPL_CNT);
				line_raddr = {idx_q, WO_W'(cnt_q)};
				back_we    = (cnt_q != '0);
			end
			ST_FILL: begin
				back_re    = (cnt_q < WPL_CNT);
				line_we    = (cnt_q != '0);
				line_waddr = {idx_q, WO_W'(cnt_q - CNT_ONE)};
				line_wdata = back_rd_q;
			end
			ST_WORD: begin
				meta_we = 1'b1;
				line_we = (func_q == FUNC_WRITE);
				line_re = (func_q != FUNC_WRITE);
			end
			default: begin
			end
		endcase
	end

	// Tag store.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		if (meta_re) begin
			meta_rd_q <= meta_mem[meta_raddr];
		end
	end

	// Line data store.
	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_waddr] <= line_wdata;
		end
		if (line_re) begin
			line_rd_q <= line_mem[line_raddr];
		end
	end

	// Backing memory.
	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_waddr] <= back_wdata;
		end
		if (back_re) begin
			back_rd_q <= back_mem[back_raddr];
		end
	end

	// Cost registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_read_cost_q    <= MEM_READ_COST_RST;
			mem_write_cost_q   <= MEM_WRITE_COST_RST;
			cache_read_cost_q  <= CACHE_READ_COST_RST;
			cache_write_cost_q <= CACHE_WRITE_COST_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MEM_READ_COST:    mem_read_cost_q    <= cfg_data;
				REG_MEM_WRITE_COST:   mem_write_cost_q   <= cfg_data;
				REG_CACHE_READ_COST:  cache_read_cost_q  <= cfg_data;
				REG_CACHE_WRITE_COST: cache_write_cost_q <= cfg_data;
			endcase
		end
	end

	// Access sequencer and time counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			time_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (func == FUNC_READ || func == FUNC_WRITE) begin
							state_q <= ST_TAG;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_TAG: begin
					cnt_q <= '0;
					if (tag_hit) begin
						state_q <= ST_WORD;
					end else if (meta_valid && meta_dirty) begin
						state_q <= ST_WB;
					end else begin
						state_q <= ST_FILL;
					end
				end
				ST_WB: begin
					if (cnt_q == WPL_CNT) begin
						cnt_q   <= '0;
						time_q  <= time_q + TIME_W'(mem_write_cost_q);
						state_q <= ST_FILL;
					end else begin
						cnt_q <= cnt_q + CNT_ONE;
					end
				end
				ST_FILL: begin
					if (cnt_q == WPL_CNT) begin
						cnt_q   <= '0;
						time_q  <= time_q + TIME_W'(mem_read_cost_q);
						state_q <= ST_WORD;
					end else begin
						cnt_q <= cnt_q + CNT_ONE;
					end
				end
				ST_WORD: begin
					if (func_q == FUNC_WRITE) begin
						time_q <= time_q + TIME_W'(cache_write_cost_q);
					end else begin
						time_q <= time_q + TIME_W'(cache_read_cost_q);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						if (func_q == FUNC_CLEAR) begin
							time_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Access word capture and lookup results.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q  <= func;
			idx_q   <= in_idx;
			tag_q   <= in_tag;
			word_q  <= in_word;
			wdata_q <= write_data;
			nbase_q <= in_blk[BW-1:0];
			hit_q   <= 1'b0;
			wb_q    <= 1'b0;
			dirty_q <= 1'b0;
		end else if (state_q == ST_TAG) begin
			hit_q   <= tag_hit;
			wb_q    <= !tag_hit && meta_valid && meta_dirty;
			dirty_q <= tag_hit && meta_dirty;
			vbase_q <= victim_blk[BW-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= (func_q == FUNC_READ) ? line_rd_q : '0;
			out_hit_q  <= hit_q;
			out_wb_q   <= wb_q;
			out_time_q <= (func_q == FUNC_CLEAR) ? '0 : time_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = out_data_q;
	assign hit          = out_hit_q;
	assign wrote_back   = out_wb_q;
	assign elapsed_time = out_time_q;

	// Checks on the sequencer.
	`DMWBC_ASSERT_NOW(a_tag_func, state_q == ST_TAG,
		func_q == FUNC_READ || func_q == FUNC_WRITE,
		"lookup started for a word that is not an access")
	`DMWBC_ASSERT_NOW(a_fill_miss, state_q == ST_FILL, !hit_q, "line fill started on a hit")
	`DMWBC_ASSERT_NEXT(a_wb_to_fill, state_q == ST_WB && cnt_q == WPL_CNT,
		state_q == ST_FILL && cnt_q == '0, "write-back not followed by a fill")
	`DMWBC_ASSERT_NOW(a_line_we, line_we, state_q == ST_FILL || state_q == ST_WORD,
		"line store written outside fill or access")
	`DMWBC_ASSERT_NEXT(a_clear_time, out_load && func_q == FUNC_CLEAR,
		time_q == '0 && out_time_q == '0, "time counter not cleared")

endmodule

// ===== tb/direct_mapped_writeback_cache_unit_tb.sv =====
// Self-checking testbench for the direct-mapped write-back cache unit.
module direct_mapped_writeback_cache_unit_tb
	import dmwbc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// The func field has one code that the block leaves without effect.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int LINES        = 256;
	localparam int LINE_WORDS   = 16;
	localparam int BACKING_SIZE = 16384;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 150;
	localparam int DIRECTED_ROWS = 20;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [DATA_W-1:0] read_word;
		logic              hit;
		logic              wrote_back;
		logic [TIME_W-1:0] elapsed;
	} cache_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              typed;
		cache_result_t     want;
	} access_row_t;

	// Directed accesses; results are typed in where they follow from reset costs.
	localparam access_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{FUNC_READ,   16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 32'd101}},
		'{FUNC_READ,   16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 32'd102}},
		'{FUNC_WRITE,  16'h0004, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 32'd103}},
		'{FUNC_READ,   16'h0004, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'd104}},
		'{FUNC_READ,   16'h4004, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1, 32'd255}},
		'{FUNC_READ,   16'h0007, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'd356}},
		'{FUNC_CLEAR,  16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 32'd0}},
		'{FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 32'd0}},
		'{FUNC_WRITE,  16'hFFFF, 32'hA5A5_5A5A, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 32'd101}},
		'{FUNC_READ,   16'hFFFC, 32'h0000_0000, 1'b0, '0},
		'{FUNC_WRITE,  16'hBFFC, 32'h5A5A_A5A5, 1'b0, '0},
		'{FUNC_READ,   16'hFFFD, 32'h0000_0000, 1'b0, '0},
		'{FUNC_WRITE,  16'hFFF0, 32'h0000_0000, 1'b0, '0},
		'{FUNC_WRITE,  16'h5554, 32'h0000_0000, 1'b0, '0},
		'{FUNC_WRITE,  16'hAAA8, 32'hFFFF_FFFF, 1'b0, '0},
		'{FUNC_READ,   16'h1554, 32'h0000_0000, 1'b0, '0},
		'{FUNC_READ,   16'hAAAB, 32'h0000_0000, 1'b0, '0},
		'{FUNC_UNUSED, 16'h1234, 32'h5555_AAAA, 1'b0, '0},
		'{FUNC_READ,   16'h3FC0, 32'h0000_0000, 1'b0, '0},
		'{FUNC_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 32'd0}}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] read_data;
	logic              hit;
	logic              wrote_back;
	logic [TIME_W-1:0] elapsed_time;
	logic              cfg_write;
	logic [REG_W-1:0]  cfg_index;
	logic [COST_W-1:0] cfg_data;

	// Shadow copy of the cache, the backing memory, the costs and the time counter.
	logic              line_valid [LINES];
	logic              line_dirty [LINES];
	logic [1:0]        line_tag [LINES];
	logic [DATA_W-1:0] cached_words [LINES*LINE_WORDS];
	logic [DATA_W-1:0] backing_words [BACKING_SIZE];
	logic [TIME_W-1:0] elapsed_count;
	logic [COST_W-1:0] mem_read_cost;
	logic [COST_W-1:0] mem_write_cost;
	logic [COST_W-1:0] cache_read_cost;
	logic [COST_W-1:0] cache_write_cost;

	cache_result_t expected_results [$];
	int            error_count = 0;
	int            sent_count = 0;
	logic          send_steady = 1'b0;
	logic [7:0]    hot_base = 8'd0;

	direct_mapped_writeback_cache_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.address      (address),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.hit          (hit),
		.wrote_back   (wrote_back),
		.elapsed_time (elapsed_time),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (error_count < 100) begin
			$display("MISMATCH at %0t ns: %s", $time, what);
		end
		error_count++;
	endtask

	// Applies one access to the shadow state and returns the word the block owes.
	function automatic cache_result_t predict_access(input logic [FUNC_W-1:0] f,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		cache_result_t r;
		logic [7:0]    idx;
		logic [1:0]    tg;
		logic [11:0]   slot;
		r = '0;
		idx = a[13:6];
		tg = a[15:14];
		slot = {idx, a[5:2]};
		if (f == FUNC_CLEAR) begin
			elapsed_count = '0;
		end else if (f == FUNC_READ || f == FUNC_WRITE) begin
			if (line_valid[idx] && line_tag[idx] == tg) begin
				r.hit = 1'b1;
			end else begin
				// A dirty victim goes back to the block named by its own tag.
				if (line_valid[idx] && line_dirty[idx]) begin
					for (int w = 0; w < LINE_WORDS; w++) begin
						backing_words[{line_tag[idx], idx, 4'(w)}] = cached_words[{idx, 4'(w)}];
					end
					elapsed_count += TIME_W'(mem_write_cost);
					r.wrote_back = 1'b1;
				end
				for (int w = 0; w < LINE_WORDS; w++) begin
					cached_words[{idx, 4'(w)}] = backing_words[{tg, idx, 4'(w)}];
				end
				elapsed_count += TIME_W'(mem_read_cost);
				line_valid[idx] = 1'b1;
				line_tag[idx] = tg;
				line_dirty[idx] = 1'b0;
			end
			if (f == FUNC_READ) begin
				r.read_word = cached_words[slot];
				elapsed_count += TIME_W'(cache_read_cost);
			end else begin
				cached_words[slot] = d;
				elapsed_count += TIME_W'(cache_write_cost);
				line_dirty[idx] = 1'b1;
			end
		end
		r.elapsed = elapsed_count;
		return r;
	endfunction

	// Most addresses fall on four neighboring lines so that tags collide often.
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] a;
		a = 16'($urandom);
		if ($urandom_range(0, 9) < 7) begin
			a[13:6] = hot_base + 8'($urandom_range(0, 3));
		end
		return a;
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return FUNC_READ;
		end else if (r < 85) begin
			return FUNC_WRITE;
		end else if (r < 95) begin
			return FUNC_CLEAR;
		end
		return FUNC_UNUSED;
	endfunction

	// Offers one word, after a random gap unless sending steadily, and records its expected result once taken.
	// Entered and left at a falling edge.
	task automatic send_access(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, input logic typed, input cache_result_t typed_want);
		int            gap;
		cache_result_t want;
		if (sent_count % 50 == 0) begin
			send_steady = ($urandom_range(0, 2) == 0);
		end
		gap = send_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		address <= a;
		write_data <= d;
		do @(posedge clk); while (in_stall !== 1'b0);
		want = predict_access(f, a, d);
		expected_results.push_back(typed ? typed_want : want);
		sent_count++;
		@(negedge clk);
	endtask

	// Holds off new words until every outstanding result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_cost(input logic [REG_W-1:0] idx, input logic [COST_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			REG_MEM_READ_COST: begin
				mem_read_cost = val;
			end
			REG_MEM_WRITE_COST: begin
				mem_write_cost = val;
			end
			REG_CACHE_READ_COST: begin
				cache_read_cost = val;
			end
			default: begin
				cache_write_cost = val;
			end
		endcase
	endtask

	// Result checker; after each word the receiver raises out_stall at random, but not while it receives steadily.
	initial begin : result_monitor
		int            hold;
		int            taken;
		logic          recv_steady;
		cache_result_t got;
		cache_result_t want;
		hold = 0;
		taken = 0;
		recv_steady = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && !out_stall) begin
				got = '{read_data, hit, wrote_back, elapsed_time};
				if (expected_results.size() == 0) begin
					report_mismatch("result word with no access outstanding");
				end else begin
					want = expected_results.pop_front();
					if (got.read_word !== want.read_word) begin
						report_mismatch($sformatf("read_data %h, expected %h",
							got.read_word, want.read_word));
					end
					if (got.hit !== want.hit) begin
						report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
					end
					if (got.wrote_back !== want.wrote_back) begin
						report_mismatch($sformatf("wrote_back %b, expected %b",
							got.wrote_back, want.wrote_back));
					end
					if (got.elapsed !== want.elapsed) begin
						report_mismatch($sformatf("elapsed_time %0d, expected %0d",
							got.elapsed, want.elapsed));
					end
				end
				if (taken % 50 == 0) begin
					recv_steady = ($urandom_range(0, 2) == 0);
				end
				taken++;
				hold = recv_steady ? 0 : $urandom_range(0, 11);
			end
			@(negedge clk);
			out_stall <= (hold > 0);
			if (hold > 0) begin
				hold--;
			end
		end
	end

	initial begin : stimulus
		cache_result_t none;
		none = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_READ;
		address = '0;
		write_data = '0;
		cfg_write = 1'b0;
		cfg_index = REG_MEM_READ_COST;
		cfg_data = '0;
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			line_tag[i] = '0;
		end
		for (int i = 0; i < LINES*LINE_WORDS; i++) begin
			cached_words[i] = '0;
		end
		for (int i = 0; i < BACKING_SIZE; i++) begin
			backing_words[i] = '0;
		end
		elapsed_count = '0;
		mem_read_cost = MEM_READ_COST_RST;
		mem_write_cost = MEM_WRITE_COST_RST;
		cache_read_cost = CACHE_READ_COST_RST;
		cache_write_cost = CACHE_WRITE_COST_RST;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part runs on the reset costs; the block takes words once it has cleared.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_access(DIRECTED[i].func, DIRECTED[i].addr, DIRECTED[i].data,
				DIRECTED[i].typed, DIRECTED[i].want);
		end

		// Random phases, each under its own cost setting, written while the block is idle.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			repeat (4) @(negedge clk);
			case (phase)
				0: begin
					write_cost(REG_MEM_READ_COST, 10'd1023);
					write_cost(REG_MEM_WRITE_COST, 10'd1023);
					write_cost(REG_CACHE_READ_COST, 10'd1023);
					write_cost(REG_CACHE_WRITE_COST, 10'd1023);
				end
				1: begin
					write_cost(REG_MEM_READ_COST, 10'd0);
					write_cost(REG_MEM_WRITE_COST, 10'd0);
					write_cost(REG_CACHE_READ_COST, 10'd0);
					write_cost(REG_CACHE_WRITE_COST, 10'd0);
				end
				3: begin
					write_cost(REG_MEM_READ_COST, 10'd0);
					write_cost(REG_MEM_WRITE_COST, 10'd1023);
					write_cost(REG_CACHE_READ_COST, 10'd1023);
					write_cost(REG_CACHE_WRITE_COST, 10'd0);
				end
				default: begin
					write_cost(REG_MEM_READ_COST, 10'($urandom));
					write_cost(REG_MEM_WRITE_COST, 10'($urandom));
					write_cost(REG_CACHE_READ_COST, 10'($urandom));
					write_cost(REG_CACHE_WRITE_COST, 10'($urandom));
				end
			endcase
			cfg_write <= 1'b0;
			hot_base = 8'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Midway through one phase the sender waits for the pipeline to empty.
				if (phase == 2 && n == PHASE_ITEMS / 2) begin
					drain_results();
				end
				send_access(pick_func(), pick_address(), pick_data(), 1'b0, none);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#3ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/dmwbc_pkg.sv
design/direct_mapped_writeback_cache_unit.sv
tb/direct_mapped_writeback_cache_unit_tb.sv
